@@ src/tdws_pkg.sv @@
package tdws_pkg;

  // Command codes carried on the command port.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_BYTE  = 2'd2
  } cmd_t;

  // Spare command code, taken and dropped without output.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Hold period after reset, in clock cycles.
  localparam logic [15:0] HOLD_RESET = 16'd135;

  // Bits in one data byte; the acknowledge slot follows them.
  localparam int BYTE_BITS = 8;
  localparam int BIT_W     = $clog2(BYTE_BITS + 1);
  localparam int SEL_W     = $clog2(BYTE_BITS);
  localparam logic [BIT_W-1:0] ACK_SLOT = BIT_W'(BYTE_BITS);

  // Three line states per bit slot or per start and stop condition.
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_MID   = 2'd1;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

endpackage

@@ src/two_wire_display_write_sequencer_core.sv @@
// Write sequencer for a two-wire seven-segment display driver, LSB first.
// Input channel (in_valid/in_ready): one word carries a command (start,
// stop or send byte) and the data byte. Output channel (out_valid/
// out_ready): one word per line state, giving the clock and data levels
// and a flag on the final state of the command's sequence.
// Start and stop produce 3 words each; a byte produces 27 words (3 per bit,
// then a 3-state acknowledge clock with data released high). Code 3 is
// taken and dropped without output.
// The first word of a command passes from the input register into the
// output register once the output slot is free and the hold period since
// the previous word has run out. Successive words are spaced by the hold
// timer, which is reloaded from hold_ticks at each word. The step counter
// frees the input register in the cycle the last word of a sequence moves
// into the output register, so the next command is taken while that word
// still waits to be read.
// Reset sets hold_ticks to 135, releases the data level high and empties
// both registers. When the receiver stalls, the output register holds its
// word and the sequence pauses; the hold timer keeps counting.
module two_wire_display_write_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clock_line,
  output logic        data_line,
  output logic        last_state
);
  import tdws_pkg::*;

  logic [15:0]      hold_ticks;
  logic [15:0]      hold_cnt;
  logic             cur_valid;
  cmd_t             cur_cmd;
  logic [7:0]       cur_byte;
  logic [BIT_W-1:0] bit_idx;
  logic [1:0]       phase;
  logic             data_level;

  logic             load;
  logic             in_take;
  logic             clk_w;
  logic             dat_w;
  logic             last_w;
  logic             bit_w;

  // Line levels for the current step of the sequence.
  always_comb begin
    bit_w  = cur_byte[bit_idx[SEL_W-1:0]];
    clk_w  = 1'b0;
    dat_w  = 1'b1;
    last_w = 1'b0;
    case (cur_cmd)
      CMD_START: begin
        clk_w  = (phase != PHASE_LAST);
        dat_w  = (phase == PHASE_FIRST);
        last_w = (phase == PHASE_LAST);
      end
      CMD_STOP: begin
        clk_w  = (phase != PHASE_FIRST);
        dat_w  = (phase == PHASE_LAST);
        last_w = (phase == PHASE_LAST);
      end
      CMD_BYTE: begin
        if (bit_idx == ACK_SLOT) begin
          clk_w  = (phase == PHASE_MID);
          dat_w  = 1'b1;
          last_w = (phase == PHASE_LAST);
        end else begin
          clk_w = (phase == PHASE_LAST);
          dat_w = (phase == PHASE_FIRST) ? data_level : bit_w;
        end
      end
      default: begin
        clk_w  = 1'b0;
        dat_w  = 1'b1;
        last_w = 1'b1;
      end
    endcase
  end

  // A word moves into the output register when the slot is free and the
  // hold period since the previous word has run out.
  assign load     = cur_valid && (!out_valid || out_ready) && (hold_cnt == 16'd0);
  assign in_ready = !cur_valid || (load && last_w);
  assign in_take  = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  // Hold timer between successive words.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 16'd0;
    end else if (load) begin
      hold_cnt <= (hold_ticks == 16'd0) ? 16'd0 : hold_ticks - 16'd1;
    end else if (hold_cnt != 16'd0) begin
      hold_cnt <= hold_cnt - 16'd1;
    end
  end

  // Input register and step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      bit_idx    <= '0;
      phase      <= PHASE_FIRST;
      data_level <= 1'b1;
    end else begin
      if (load) begin
        if (phase == PHASE_LAST) begin
          phase   <= PHASE_FIRST;
          bit_idx <= bit_idx + BIT_W'(1);
        end else begin
          phase <= phase + 2'd1;
        end
        // The data level follows the last driven data state of each slot.
        if (phase == PHASE_LAST) begin
          data_level <= dat_w;
        end
        if (last_w) begin
          cur_valid <= 1'b0;
        end
      end
      if (in_take) begin
        cur_valid <= (command != CMD_UNUSED);
        bit_idx   <= '0;
        phase     <= PHASE_FIRST;
      end
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_cmd  <= cmd_t'(command);
      cur_byte <= data_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clock_line <= clk_w;
      data_line  <= dat_w;
      last_state <= last_w;
    end
  end

  // The phase counter never reaches its unused code.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (phase != 2'd3))
    else $error("phase counter out of range");

  // A byte sequence never runs past its acknowledge slot.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (bit_idx <= ACK_SLOT))
    else $error("bit index past acknowledge slot");

  // Loading the final word frees the input register unless a new word is taken.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (load && last_w && !in_take) |=> !cur_valid)
    else $error("sequence did not end after its last word");

  // The hold timer stays below the configured period.
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    (load && !cfg_we) |=> (hold_cnt == 16'd0 || hold_cnt < hold_ticks))
    else $error("hold timer above configured period");

endmodule
